FILE: rtl/segment_pair_intersection_count_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment pair intersection counter.
// Both macros sample on the rising edge of clk_i and are off during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_INTERSECTION_COUNT_CORE_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_COUNT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spic_pkg.sv
// ----------------------------------------------------------------------------
// spic_pkg
// Shared constants and types of the segment pair intersection counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spic_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF   = 16;

  // Result field widths; wider internal values are truncated to these.
  localparam int unsigned CROSS_W = 11;
  localparam int unsigned TESTS_W = 13;
  localparam int unsigned USED_W  = 7;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_DRAIN
  } state_e;

endpackage

FILE: rtl/segment_pair_intersection_count_core.sv
// Loading: while in_stall_o is low, one segment beat per cycle is written to the
// store if it has room, else dropped and flagged. The beat marked last starts an
// all-pairs sweep of the n segments stored, one ordered pair read from the dual-read
// segment store each cycle; input stalls until the result is registered.
// Reset (rst_ni low, asynchronous) empties the set and clears all control state;
// store contents are left as they are and only entries written since are read.
// ----------------------------------------------------------------------------
// segment_pair_intersection_count_core
// Stores line segments and counts intersecting pairs by brute-force testing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_pair_intersection_count_core #(
  parameter int unsigned MAX_SEGMENTS = spic_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = spic_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [COORD_BITS-1:0]       start_x_i,
  input  logic [COORD_BITS-1:0]       start_y_i,
  input  logic [COORD_BITS-1:0]       end_x_i,
  input  logic [COORD_BITS-1:0]       end_y_i,
  input  logic                        last_segment_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spic_pkg::CROSS_W-1:0] crossing_pairs_o,
  output logic [spic_pkg::TESTS_W-1:0] pair_tests_o,
  output logic [spic_pkg::USED_W-1:0]  segments_used_o,
  output logic                        overflow_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned HIT_W = 2 * CNT_W;
  localparam int unsigned SEG_W = 4 * COORD_BITS;
  localparam int unsigned D_W   = COORD_BITS + 1;
  localparam int unsigned P_W   = 2 * D_W;
  localparam int unsigned R_W   = P_W + 1;

  // A parameter lies in [0,1] when its numerator has the sign of the
  // determinant and does not exceed it in magnitude.
  function automatic logic in_unit(input logic signed [R_W-1:0] num,
                                   input logic signed [R_W-1:0] den);
    logic res;
    if (!den[R_W-1]) begin
      res = !num[R_W-1] && (num <= den);
    end else begin
      res = (num[R_W-1] || (num == '0)) && (num >= den);
    end
    return res;
  endfunction

  spic_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic             dropped_q, dropped_d;
  logic [HIT_W-1:0] hits_q, hits_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic [3:0]       pipe_v_q;
  logic             out_valid_q, out_valid_d;

  logic in_accept, store_full, mem_we, issue, out_load, hit;
  logic i_last, j_last;

  logic [SEG_W-1:0] seg_mem_q [MAX_SEGMENTS];
  logic [SEG_W-1:0] rd_p_q, rd_q_q;

  logic signed [D_W-1:0] dpx_d, dpy_d, dqx_d, dqy_d, ox_d, oy_d;
  logic signed [D_W-1:0] dpx_q, dpy_q, dqx_q, dqy_q, ox_q, oy_q;
  logic signed [P_W-1:0] m1_d, m2_d, m3_d, m4_d, m5_d, m6_d;
  logic signed [P_W-1:0] m1_q, m2_q, m3_q, m4_q, m5_q, m6_q;
  logic signed [R_W-1:0] det_d, ns_d, nt_d, det_q, ns_q, nt_q;

  logic [2*CNT_W-1:0] count_sq;
  logic [HIT_W-1:0]   half_hits;

  logic [spic_pkg::CROSS_W-1:0] crossing_q;
  logic [spic_pkg::TESTS_W-1:0] tests_q;
  logic [spic_pkg::USED_W-1:0]  used_q;
  logic                         overflow_q;

  assign in_stall_o = (state_q != spic_pkg::ST_LOAD);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign store_full = (count_q == CNT_W'(MAX_SEGMENTS));
  assign i_last     = (CNT_W'(i_q) == count_q - CNT_W'(1));
  assign j_last     = (CNT_W'(j_q) == count_q - CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    hits_d      = hits_q;
    i_d         = i_q;
    j_d         = j_q;
    issue       = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (pipe_v_q[3]) begin
      hits_d = hits_q + HIT_W'(hit);
    end
    case (state_q)
      spic_pkg::ST_LOAD: begin
        if (in_accept) begin
          if (!store_full) begin
            mem_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_segment_i) begin
            hits_d  = '0;
            i_d     = '0;
            j_d     = '0;
            state_d = spic_pkg::ST_SWEEP;
          end
        end
      end
      spic_pkg::ST_SWEEP: begin
        issue = 1'b1;
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            state_d = spic_pkg::ST_DRAIN;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      spic_pkg::ST_DRAIN: begin
        if ((pipe_v_q == '0) && (!out_valid_q || !out_stall_i)) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          count_d     = '0;
          dropped_d   = 1'b0;
          hits_d      = '0;
          state_d     = spic_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = spic_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spic_pkg::ST_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      hits_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pipe_v_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      hits_q      <= hits_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pipe_v_q    <= {pipe_v_q[2:0], issue};
      out_valid_q <= out_valid_d;
    end
  end

  // Segment store: one write port for loading, two read ports for the sweep.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem_q[count_q[IDX_W-1:0]] <= {start_x_i, start_y_i, end_x_i, end_y_i};
    end
    rd_p_q <= seg_mem_q[i_q];
    rd_q_q <= seg_mem_q[j_q];
  end

  assign dpx_d = $signed({1'b0, rd_p_q[2*COORD_BITS-1 -: COORD_BITS]})
               - $signed({1'b0, rd_p_q[4*COORD_BITS-1 -: COORD_BITS]});
  assign dpy_d = $signed({1'b0, rd_p_q[COORD_BITS-1:0]})
               - $signed({1'b0, rd_p_q[3*COORD_BITS-1 -: COORD_BITS]});
  assign dqx_d = $signed({1'b0, rd_q_q[2*COORD_BITS-1 -: COORD_BITS]})
               - $signed({1'b0, rd_q_q[4*COORD_BITS-1 -: COORD_BITS]});
  assign dqy_d = $signed({1'b0, rd_q_q[COORD_BITS-1:0]})
               - $signed({1'b0, rd_q_q[3*COORD_BITS-1 -: COORD_BITS]});
  assign ox_d  = $signed({1'b0, rd_q_q[4*COORD_BITS-1 -: COORD_BITS]})
               - $signed({1'b0, rd_p_q[4*COORD_BITS-1 -: COORD_BITS]});
  assign oy_d  = $signed({1'b0, rd_q_q[3*COORD_BITS-1 -: COORD_BITS]})
               - $signed({1'b0, rd_p_q[3*COORD_BITS-1 -: COORD_BITS]});

  assign m1_d = dqx_q * dpy_q;
  assign m2_d = dqy_q * dpx_q;
  assign m3_d = dqx_q * oy_q;
  assign m4_d = dqy_q * ox_q;
  assign m5_d = dpx_q * oy_q;
  assign m6_d = dpy_q * ox_q;

  assign det_d = $signed({m1_q[P_W-1], m1_q}) - $signed({m2_q[P_W-1], m2_q});
  assign ns_d  = $signed({m3_q[P_W-1], m3_q}) - $signed({m4_q[P_W-1], m4_q});
  assign nt_d  = $signed({m5_q[P_W-1], m5_q}) - $signed({m6_q[P_W-1], m6_q});

  // A zero determinant covers parallel, collinear and self pairs.
  assign hit = (det_q != '0) && in_unit(ns_q, det_q) && in_unit(nt_q, det_q);

  always_ff @(posedge clk_i) begin
    dpx_q <= dpx_d;
    dpy_q <= dpy_d;
    dqx_q <= dqx_d;
    dqy_q <= dqy_d;
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    m3_q  <= m3_d;
    m4_q  <= m4_d;
    m5_q  <= m5_d;
    m6_q  <= m6_d;
    det_q <= det_d;
    ns_q  <= ns_d;
    nt_q  <= nt_d;
  end

  assign count_sq  = count_q * count_q;
  assign half_hits = hits_q >> 1;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      crossing_q <= spic_pkg::CROSS_W'(half_hits);
      tests_q    <= spic_pkg::TESTS_W'(count_sq);
      used_q     <= spic_pkg::USED_W'(count_q);
      overflow_q <= dropped_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign crossing_pairs_o = crossing_q;
  assign pair_tests_o     = tests_q;
  assign segments_used_o  = used_q;
  assign overflow_o       = overflow_q;

endmodule

FILE: rtl/spic_checker.sv
// ----------------------------------------------------------------------------
// spic_checker
// Port-level checks of the segment pair intersection counter, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "segment_pair_intersection_count_core_assert.svh"

module spic_checker #(
  parameter int unsigned MAX_SEGMENTS = spic_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = spic_pkg::COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [COORD_BITS-1:0]        start_x_i,
  input logic [COORD_BITS-1:0]        start_y_i,
  input logic [COORD_BITS-1:0]        end_x_i,
  input logic [COORD_BITS-1:0]        end_y_i,
  input logic                         last_segment_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [spic_pkg::CROSS_W-1:0] crossing_pairs_o,
  input logic [spic_pkg::TESTS_W-1:0] pair_tests_o,
  input logic [spic_pkg::USED_W-1:0]  segments_used_o,
  input logic                         overflow_o
);

  // Field relations only hold while no result field is truncated.
  localparam logic EXACT = (MAX_SEGMENTS <= 64);

  logic [13:0] used_sq;
  logic [13:0] hit_bound;

  assign used_sq   = segments_used_o * segments_used_o;
  // Self pairs never hit, so crossings are at most (n*n - n) / 2.
  assign hit_bound = {2'b00, crossing_pairs_o, 1'b0} + 14'(segments_used_o);

  `SPIC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(crossing_pairs_o) && $stable(pair_tests_o) && $stable(segments_used_o) && $stable(overflow_o), "stalled result changed")
  `SPIC_ASSERT_NEXT(a_last_stalls, in_valid_i && !in_stall_o && last_segment_i, in_stall_o, "input not stalled during sweep")
  `SPIC_ASSERT_SAME(a_tests_square, EXACT && out_valid_o, pair_tests_o == used_sq[12:0], "pair_tests is not segments_used squared")
  `SPIC_ASSERT_SAME(a_hits_bound, EXACT && out_valid_o, hit_bound <= 14'(pair_tests_o), "crossing_pairs exceeds pair bound")

endmodule

bind segment_pair_intersection_count_core spic_checker #(
  .MAX_SEGMENTS(MAX_SEGMENTS),
  .COORD_BITS  (COORD_BITS)
) u_spic_checker (.*);
